// ===== hdl/ccs_pkg.sv =====
package ccs_pkg;

  localparam logic [15:0] CoinWeightRst   = 16'd574;
  localparam logic [7:0]  AvgCountRst     = 8'd100;
  localparam logic [15:0] ScaleGainRst    = 16'd18030;
  localparam logic [15:0] ScaleOffsetRst  = 16'd40;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgCoinWeight  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAvgCount    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScaleGain   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgScaleOffset = 2'd3;

  localparam logic [1:0] ActSample = 2'd0;
  localparam logic [1:0] ActTare   = 2'd1;
  localparam logic [1:0] ActStart  = 2'd2;
  localparam logic [1:0] ActReport = 2'd3;

  localparam logic [2:0] StIgnored  = 3'd0;
  localparam logic [2:0] StTared    = 3'd1;
  localparam logic [2:0] StStarted  = 3'd2;
  localparam logic [2:0] StReport   = 3'd3;
  localparam logic [2:0] StAccum    = 3'd4;
  localparam logic [2:0] StMean     = 3'd5;
  localparam logic [2:0] StMeanKept = 3'd6;

  // divider operand width: signed dividend up to 40 bits, 16 bit divisor
  localparam int unsigned DivW = 48;

  localparam logic signed [31:0] MassMax = 32'sh7fffffff;
  localparam logic signed [31:0] MassMin = 32'sh80000000;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] period_a;
    logic [15:0] period_b;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               period_error;
    logic signed [31:0] tare_mass;
    logic signed [31:0] net_mass;
    logic signed [31:0] gross_mass;
    logic [15:0]        coin_total;
    logic [7:0]         led_pattern;
  } out_word_t;

  typedef struct packed {
    logic                   start;
    logic signed [DivW-1:0] dividend;
    logic [15:0]            divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [DivW-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [DivW-1:0] v);
    if (v > DivW'(MassMax)) return MassMax;
    if (v < DivW'(MassMin)) return MassMin;
    return v[31:0];
  endfunction

endpackage

// ===== hdl/coin_counting_scale.sv =====
// Coin counting scale. One word is handled at a time: the input is ready only
// while the block is idle, and a shared 48 step divider (one quotient bit a
// cycle) does the mass, mean and coin count divisions in turn. A tare word
// uses the mass division, a start, report or ignored word none, and a sample
// up to all three (a zero reference period skips the mass division, a zero
// mean the coin count). The result sits in an output register and the next
// word is taken only after the result has been accepted. Write configuration
// only while no word is in flight.
module coin_counting_scale #(
  parameter logic [15:0] CoinWeightReset  = ccs_pkg::CoinWeightRst,
  parameter logic [7:0]  AvgCountReset    = ccs_pkg::AvgCountRst,
  parameter logic [15:0] ScaleGainReset   = ccs_pkg::ScaleGainRst,
  parameter logic [15:0] ScaleOffsetReset = ccs_pkg::ScaleOffsetRst
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ccs_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ccs_pkg::out_word_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [ccs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [15:0]                       cfg_data_i
);
  import ccs_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SMul    = 4'd1;
  localparam logic [3:0] SKey    = 4'd2;
  localparam logic [3:0] SMass   = 4'd3;
  localparam logic [3:0] SSamp   = 4'd4;
  localparam logic [3:0] SMean   = 4'd5;
  localparam logic [3:0] SCoinGo = 4'd6;
  localparam logic [3:0] SCoin   = 4'd7;
  localparam logic [3:0] SOut    = 4'd8;

  logic [15:0] cw_q, gain_q, offs_q;
  logic [7:0]  avg_q;

  logic [3:0]  st_q, st_d;
  logic        tared_q, weigh_q, rep_q;
  logic signed [31:0] tare_q, mean_q, mass_q;
  logic signed [39:0] sum_q;
  logic [7:0]  cnt_q;
  logic [15:0] coin_q;
  logic [7:0]  led_q;
  in_word_t    in_q;
  logic        err_q;
  logic [2:0]  status_q;
  logic        shown_q;
  logic signed [31:0] sh_tare_q, sh_mean_q;
  logic signed [33:0] prod_a_q;
  logic [31:0] prod_b_q;

  div_req_t dreq;
  div_rsp_t drsp;

  ccs_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic [15:0] cw_eff;
  logic signed [16:0] pdiff;
  logic signed [DivW-1:0] mass_num, coin_num;
  logic signed [31:0] quo32, net32, out_tare, out_mean;
  logic in_acc, out_acc;
  logic tare_ok, start_ok, rep_ok, samp_ok, mass_go;
  logic coin_pos, coin_big;

  assign cw_eff = (cw_q == '0) ? 16'd1 : cw_q;
  assign in_ready_o = (st_q == SIdle);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_valid_o = (st_q == SOut);
  assign out_acc = out_valid_o && out_ready_i;

  assign tare_ok  = (in_q.action == ActTare) && !tared_q && !weigh_q;
  assign start_ok = (in_q.action == ActStart) && tared_q && !weigh_q;
  assign rep_ok   = (in_q.action == ActReport) && !rep_q && tared_q && weigh_q;
  assign samp_ok  = (in_q.action == ActSample) && tared_q && weigh_q;
  assign mass_go  = (tare_ok || samp_ok) && (in_q.period_b != '0);

  // numerator of the mass: gain*(pa-pb) - offset*pb
  assign pdiff = $signed({1'b0, in_q.period_a}) - $signed({1'b0, in_q.period_b});
  assign mass_num = DivW'(prod_a_q) - DivW'($signed({1'b0, prod_b_q}));
  assign coin_num = DivW'(mean_q) * DivW'(100) + DivW'($signed({1'b0, cw_eff[15:1]}));

  assign quo32 = sat32(drsp.quotient);
  assign net32 = sat32(DivW'(mass_q) - DivW'(tare_q));
  assign coin_pos = !drsp.quotient[DivW-1] && (drsp.quotient != '0);
  assign coin_big = |drsp.quotient[DivW-2:16];

  always_ff @(posedge clk_i) begin
    prod_a_q <= $signed({1'b0, gain_q}) * pdiff;
    prod_b_q <= offs_q * in_q.period_b;
  end

  always_comb begin
    dreq = '0;
    st_d = st_q;
    case (st_q)
      SIdle: if (in_acc) st_d = SMul;
      SMul: st_d = SKey;
      SKey: begin
        st_d = SOut;
        if (mass_go) begin
          dreq.start = 1'b1;
          dreq.dividend = mass_num;
          dreq.divisor = in_q.period_b;
          st_d = SMass;
        end else if (samp_ok) begin
          st_d = SSamp;
        end
      end
      SMass: if (drsp.done) st_d = (in_q.action == ActTare) ? SOut : SSamp;
      SSamp: begin
        st_d = SCoinGo;
        if (cnt_q >= avg_q && cnt_q != '0) begin
          dreq.start = 1'b1;
          dreq.dividend = DivW'(sum_q);
          dreq.divisor = {8'h00, cnt_q};
          st_d = SMean;
        end
      end
      SMean: if (drsp.done) st_d = SCoinGo;
      SCoinGo: begin
        st_d = SOut;
        if (mean_q != '0) begin
          dreq.start = 1'b1;
          dreq.dividend = coin_num;
          dreq.divisor = cw_eff;
          st_d = SCoin;
        end
      end
      SCoin: if (drsp.done) st_d = SOut;
      SOut: if (out_acc) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cw_q <= CoinWeightReset; avg_q <= AvgCountReset;
      gain_q <= ScaleGainReset; offs_q <= ScaleOffsetReset;
      tared_q <= 1'b0; weigh_q <= 1'b0; rep_q <= 1'b0;
      tare_q <= '0; mean_q <= '0; mass_q <= '0; sum_q <= '0; cnt_q <= '0;
      coin_q <= '0; led_q <= '0; in_q <= '0; err_q <= 1'b0;
      status_q <= StIgnored; shown_q <= 1'b0; sh_tare_q <= '0; sh_mean_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCoinWeight:  cw_q <= cfg_data_i;
          CfgAvgCount:    avg_q <= cfg_data_i[7:0];
          CfgScaleGain:   gain_q <= cfg_data_i;
          CfgScaleOffset: offs_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        SIdle: if (in_acc) begin
          in_q <= in_data_i; err_q <= 1'b0; status_q <= StIgnored; shown_q <= 1'b0;
        end
        SKey: begin
          if (tare_ok) begin
            led_q <= '0; tared_q <= 1'b1; rep_q <= 1'b0; status_q <= StTared;
            if (in_q.period_b == '0) begin
              err_q <= 1'b1; tare_q <= '0;
            end
          end else if (start_ok) begin
            weigh_q <= 1'b1; status_q <= StStarted;
          end else if (rep_ok) begin
            // report shows the session values from before the clear
            sh_tare_q <= tare_q; sh_mean_q <= mean_q; shown_q <= 1'b1;
            tared_q <= 1'b0; weigh_q <= 1'b0; cnt_q <= '0; sum_q <= '0;
            tare_q <= '0; mean_q <= '0; rep_q <= 1'b1; status_q <= StReport;
          end else if (samp_ok) begin
            mass_q <= '0;
            if (in_q.period_b == '0) err_q <= 1'b1;
          end
        end
        SMass: if (drsp.done) begin
          if (in_q.action == ActTare) tare_q <= quo32;
          else mass_q <= quo32;
        end
        SSamp: begin
          if (cnt_q >= avg_q) begin
            // sample dropped; the mean division of sum by count starts here unless the count is zero
            status_q <= (cnt_q == '0) ? StMeanKept : StMean;
            sum_q <= '0; cnt_q <= '0;
          end else begin
            sum_q <= sum_q + 40'(net32); cnt_q <= cnt_q + 8'd1; status_q <= StAccum;
          end
        end
        SMean: if (drsp.done) mean_q <= quo32;
        SCoin: if (drsp.done) begin
          if (coin_pos) begin
            coin_q <= coin_big ? 16'hffff : drsp.quotient[15:0];
            led_q <= drsp.quotient[7:0];
          end else begin
            led_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tare = shown_q ? sh_tare_q : tare_q;
  assign out_mean = shown_q ? sh_mean_q : mean_q;

  always_comb begin
    out_data_o.status       = status_q;
    out_data_o.period_error = err_q;
    out_data_o.tare_mass    = out_tare;
    out_data_o.net_mass     = out_mean;
    out_data_o.gross_mass   = sat32(DivW'(out_tare) + DivW'(out_mean));
    out_data_o.coin_total   = coin_q;
    out_data_o.led_pattern  = led_q;
  end

  a_rdy_vld_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while waiting");
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q <= SOut) else $error("illegal state");
  a_tare_leds_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StTared |-> out_data_o.led_pattern == '0)
    else $error("leds lit after tare");
endmodule

// ===== hdl/ccs_div.sv =====
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module ccs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccs_pkg::div_req_t  req_i,
  output ccs_pkg::div_rsp_t  rsp_o
);
  import ccs_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] quo_q, quo_d;
  logic [16:0]     rem_q, rem_d;
  logic [15:0]     dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DivW-1:0] mag;
  logic [17:0]     trial;

  always_comb begin
    mag = req_i.dividend[DivW-1] ? DivW'(-req_i.dividend) : req_i.dividend;
    trial = {rem_q, quo_q[DivW-1]} - {2'b00, dvs_q};
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      quo_d = mag; rem_d = '0; dvs_d = req_i.divisor;
      neg_d = req_i.dividend[DivW-1]; cnt_d = CntW'(DivW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[DivW-1]};
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d; neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = neg_q ? DivW'(-quo_q) : quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
endmodule

// ===== sim/coin_counting_scale_tb.sv =====
module coin_counting_scale_tb;
  import ccs_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  coin_counting_scale uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scale model state
  longint cw_m, avg_m, gain_m, off_m;
  bit     tared_m, weighing_m, reported_m;
  longint tare_m, sum_m, cnt_m, mean_m, coins_m, leds_m;

  out_word_t pending_q[$];
  int   n_errors = 0;
  int   hold_cnt = 0;
  bit   quiet = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint weigh(longint pa, longint pb, ref bit err);
    if (pb == 0) begin
      err = 1'b1;
      return 0;
    end
    return clamp32((gain_m * (pa - pb) - off_m * pb) / pb);
  endfunction

  function automatic void update_coins();
    longint w, q;
    w = (cw_m == 0) ? 1 : cw_m;
    if (mean_m == 0) return;
    q = (mean_m * 100 + w / 2) / w;
    if (q > 0) begin
      coins_m = (q > 65535) ? 65535 : q;
      leds_m  = q & 8'hff;
    end else begin
      leds_m = 0;
    end
  endfunction

  function automatic out_word_t weigh_step(in_word_t w);
    out_word_t r;
    bit     err;
    longint shown_tare, shown_mean, net;
    err = 1'b0;
    r.status = StIgnored;
    shown_tare = tare_m;
    shown_mean = mean_m;
    case (w.action)
      ActTare: begin
        if (!tared_m && !weighing_m) begin
          leds_m = 0;
          tare_m = weigh(w.period_a, w.period_b, err);
          tared_m = 1'b1;
          reported_m = 1'b0;
          r.status = StTared;
        end
      end
      ActStart: begin
        if (tared_m && !weighing_m) begin
          weighing_m = 1'b1;
          r.status = StStarted;
        end
      end
      ActReport: begin
        if (!reported_m && tared_m && weighing_m) begin
          tared_m = 1'b0;
          weighing_m = 1'b0;
          cnt_m = 0;
          sum_m = 0;
          tare_m = 0;
          mean_m = 0;
          reported_m = 1'b1;
          r.status = StReport;
        end
      end
      default: begin
        if (tared_m && weighing_m) begin
          net = clamp32(weigh(w.period_a, w.period_b, err) - tare_m);
          if (cnt_m >= avg_m) begin
            if (cnt_m == 0) begin
              r.status = StMeanKept;
            end else begin
              mean_m = clamp32(sum_m / cnt_m);
              r.status = StMean;
            end
            sum_m = 0;
            cnt_m = 0;
          end else begin
            sum_m += net;
            cnt_m++;
            r.status = StAccum;
          end
          update_coins();
        end
      end
    endcase
    if (r.status != StReport) begin
      shown_tare = tare_m;
      shown_mean = mean_m;
    end
    r.period_error = err;
    r.tare_mass    = shown_tare[31:0];
    r.net_mass     = shown_mean[31:0];
    r.gross_mass   = 32'(clamp32(shown_tare + shown_mean));
    r.coin_total   = coins_m[15:0];
    r.led_pattern  = leds_m[7:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    n_errors++;
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
  endtask

  // receiver: random stalls plus a single long hold-off
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.status != e.status)
          report_mismatch("status", out_data_o.status, e.status);
        if (out_data_o.period_error != e.period_error)
          report_mismatch("period_error", out_data_o.period_error, e.period_error);
        if (out_data_o.tare_mass != e.tare_mass)
          report_mismatch("tare_mass", out_data_o.tare_mass, e.tare_mass);
        if (out_data_o.net_mass != e.net_mass)
          report_mismatch("net_mass", out_data_o.net_mass, e.net_mass);
        if (out_data_o.gross_mass != e.gross_mass)
          report_mismatch("gross_mass", out_data_o.gross_mass, e.gross_mass);
        if (out_data_o.coin_total != e.coin_total)
          report_mismatch("coin_total", out_data_o.coin_total, e.coin_total);
        if (out_data_o.led_pattern != e.led_pattern)
          report_mismatch("led_pattern", out_data_o.led_pattern, e.led_pattern);
      end
    end
  end

  // typed rows override status and error flag with the table value
  task automatic send_word(in_word_t w, bit typed = 1'b0, logic [2:0] st = StIgnored,
                           bit err = 1'b0);
    out_word_t e;
    int gap;
    if (!quiet && $urandom_range(99) < 10) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    e = weigh_step(w);
    if (typed) begin
      e.status = st;
      e.period_error = err;
    end
    pending_q.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (200) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCoinWeight: cw_m  = val;
      CfgAvgCount:   avg_m = val[7:0];
      CfgScaleGain:  gain_m = val;
      default:       off_m = val;
    endcase
  endtask

  task automatic set_regs(logic [15:0] cw, logic [7:0] avg, logic [15:0] g, logic [15:0] o);
    cfg_write(CfgCoinWeight, cw);
    cfg_write(CfgAvgCount, {8'h00, avg});
    cfg_write(CfgScaleGain, g);
    cfg_write(CfgScaleOffset, o);
  endtask

  function automatic in_word_t rand_sample(logic [1:0] act);
    in_word_t w;
    int unsigned sel, pb, delta;
    sel = $urandom_range(9);
    w.action = act;
    if (sel < 3) begin
      w.period_a = 16'($urandom);
      w.period_b = 16'($urandom);
    end else if (sel == 3) begin
      w.period_a = 16'($urandom);
      w.period_b = 16'd0;
    end else begin
      // near-balanced periods give masses in a useful range
      pb = $urandom_range(20000, 40000);
      delta = $urandom_range(0, 3000);
      w.period_b = 16'(pb);
      w.period_a = 16'((sel < 8) ? pb + delta : pb - delta);
    end
    return w;
  endfunction

  typedef struct {
    logic [1:0]  act;
    logic [15:0] pa;
    logic [15:0] pb;
    bit          typed;
    logic [2:0]  st;
    bit          err;
  } stim_row_t;

  stim_row_t dir_tbl[] = '{
    '{ActSample, 16'd100,   16'd100,   1'b1, StIgnored,  1'b0},
    '{ActStart,  16'd0,     16'd0,     1'b1, StIgnored,  1'b0},
    '{ActReport, 16'hffff,  16'hffff,  1'b1, StIgnored,  1'b0},
    '{ActTare,   16'd500,   16'd0,     1'b1, StTared,    1'b1},
    '{ActTare,   16'd500,   16'd1000,  1'b1, StIgnored,  1'b0},
    '{ActReport, 16'd0,     16'd0,     1'b1, StIgnored,  1'b0},
    '{ActStart,  16'd0,     16'd0,     1'b1, StStarted,  1'b0},
    '{ActStart,  16'd0,     16'd0,     1'b1, StIgnored,  1'b0},
    '{ActTare,   16'd1,     16'd1,     1'b1, StIgnored,  1'b0},
    '{ActSample, 16'hffff,  16'd1,     1'b1, StAccum,    1'b0},
    '{ActSample, 16'd0,     16'd0,     1'b1, StAccum,    1'b1},
    '{ActSample, 16'd0,     16'hffff,  1'b1, StMean,     1'b0},
    '{ActSample, 16'd31000, 16'd30000, 1'b0, StIgnored,  1'b0},
    '{ActSample, 16'd32000, 16'd30000, 1'b0, StIgnored,  1'b0},
    '{ActSample, 16'd30000, 16'd30000, 1'b0, StIgnored,  1'b0},
    '{ActSample, 16'd1,     16'hffff,  1'b0, StIgnored,  1'b0},
    '{ActReport, 16'd0,     16'd0,     1'b1, StReport,   1'b0},
    '{ActReport, 16'd0,     16'd0,     1'b1, StIgnored,  1'b0},
    '{ActSample, 16'd5,     16'd0,     1'b1, StIgnored,  1'b0},
    '{ActTare,   16'd30000, 16'd30000, 1'b1, StTared,    1'b0},
    '{ActStart,  16'd0,     16'd0,     1'b1, StStarted,  1'b0},
    '{ActSample, 16'd33000, 16'd30000, 1'b0, StIgnored,  1'b0},
    '{ActReport, 16'd0,     16'd0,     1'b1, StReport,   1'b0}
  };

  // cw, avg, gain, offset per random phase; extremes and odd corners included
  logic [15:0] phase_cfg[8][4] = '{
    '{16'd574,   16'd4,   16'd18030, 16'd40},
    '{16'd1,     16'd1,   16'd0,     16'd0},
    '{16'hffff,  16'd255, 16'hffff,  16'hffff},
    '{16'd0,     16'd0,   16'd18030, 16'd40},
    '{16'd100,   16'd3,   16'd1000,  16'hffff},
    '{16'd7,     16'd6,   16'hffff,  16'd0},
    '{16'd574,   16'd100, 16'd18030, 16'd40},
    '{16'd2,     16'd2,   16'd500,   16'd12}
  };

  initial begin
    in_word_t w;
    int n_samples, smax;
    cw_m = CoinWeightRst; avg_m = AvgCountRst; gain_m = ScaleGainRst; off_m = ScaleOffsetRst;
    tared_m = 0; weighing_m = 0; reported_m = 0;
    tare_m = 0; sum_m = 0; cnt_m = 0; mean_m = 0; coins_m = 0; leds_m = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cfg_write(CfgAvgCount, 16'd2);
    foreach (dir_tbl[i]) begin
      w = '{dir_tbl[i].act, dir_tbl[i].pa, dir_tbl[i].pb};
      send_word(w, dir_tbl[i].typed, dir_tbl[i].st, dir_tbl[i].err);
    end
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      set_regs(phase_cfg[p][0], phase_cfg[p][1][7:0], phase_cfg[p][2], phase_cfg[p][3]);
      quiet = (p == 1);
      if (p == 4) hold_cnt = 3000;
      for (int k = 0; k < 200; ) begin
        if ($urandom_range(99) < 15) begin
          // noise: any action with any periods
          send_word(rand_sample(2'($urandom_range(3))));
          k++;
        end else begin
          send_word(rand_sample(ActTare));
          send_word(rand_sample(ActStart));
          smax = int'((avg_m <= 8) ? 3 * avg_m + 2 : avg_m + 5);
          if (smax > 40 && $urandom_range(3) != 0) smax = 40;
          n_samples = int'($urandom_range(0, smax));
          for (int s = 0; s < n_samples; s++) send_word(rand_sample(ActSample));
          if ($urandom_range(9) != 0) send_word(rand_sample(ActReport));
          k += n_samples + 3;
        end
      end
      if (p == 5) wait_drained();
      send_word(rand_sample(ActReport));
      wait_drained();
    end
    quiet = 1'b0;

    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ccs_pkg.sv
hdl/ccs_div.sv
hdl/coin_counting_scale.sv
sim/coin_counting_scale_tb.sv
